// ----- rtl/core/keyframe_vec3_sampler_defines.svh -----
// ----------------------------------------------------------------------------
// keyframe_vec3_sampler assertion macros
// shared concurrent assertion forms, clocked on clk and gated by rst_n
// ----------------------------------------------------------------------------
`ifndef KEYFRAME_VEC3_SAMPLER_DEFINES_SVH
`define KEYFRAME_VEC3_SAMPLER_DEFINES_SVH

// same-cycle implication
`define KVS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kvs check failed");

// next-cycle implication
`define KVS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kvs check failed");

`endif

// ----- rtl/core/kvs_pkg.sv -----
// ----------------------------------------------------------------------------
// kvs_pkg
// types and constants shared by the keyframe sampler modules
// ----------------------------------------------------------------------------
package kvs_pkg;

    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 96;
    localparam int QUO_W      = 48;
    localparam int QCNT_W     = 6;

    localparam logic CFG_KEY_COUNT = 1'b0;
    localparam logic CFG_LOOPING   = 1'b1;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef struct packed {
        logic        is_sample;
        logic        wr_ok;
        logic [5:0]  slot;
        logic [31:0] time_q16;
        logic [31:0] value_x;
        logic [31:0] value_y;
        logic [31:0] value_z;
    } kvs_req_t;

    typedef struct packed {
        logic [31:0] time_q16;
        logic [31:0] value_x;
        logic [31:0] value_y;
        logic [31:0] value_z;
    } kvs_key_t;

    typedef struct packed {
        logic        start;
        logic [32:0] num;
        logic [32:0] den;
    } kvs_div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [31:0] f;
    } kvs_div_rsp_t;

endpackage

// ----- rtl/core/kvs_front.sv -----
// ----------------------------------------------------------------------------
// kvs_front
// config registers, request decode and a two-entry request queue
// ----------------------------------------------------------------------------
module kvs_front
    import kvs_pkg::*;
#(
    parameter int MAX_KEYS = 64,
    parameter int CW       = 7
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [6:0]           cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    input  logic [0:0]           s_tuser,
    output logic                 req_valid,
    input  logic                 req_pop,
    output kvs_req_t             req,
    output logic [CW-1:0]        eff_cnt
);

    logic [6:0]  key_count_reg;
    logic        looping_reg;
    kvs_req_t    fifo_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        push;
    kvs_req_t    in_req;
    logic [31:0] kc32;
    logic [31:0] cnt32;
    logic [31:0] eff32;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg <= 7'd1;
            looping_reg   <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_KEY_COUNT: key_count_reg <= cfg_data;
                CFG_LOOPING:   looping_reg   <= cfg_data[0];
                default:       key_count_reg <= key_count_reg;
            endcase
        end
    end

    always_comb
    begin
        kc32 = {25'd0, key_count_reg};
        if (kc32 == 32'd0)
            cnt32 = 32'd1;
        else if (kc32 > 32'(MAX_KEYS))
            cnt32 = 32'(MAX_KEYS);
        else
            cnt32 = kc32;
        eff32 = looping_reg ? cnt32 - 32'd1 : cnt32;
    end

    assign eff_cnt = CW'(eff32);

    always_comb
    begin
        in_req.is_sample = (s_tuser[0] == OP_SAMPLE);
        in_req.wr_ok     = ({26'd0, s_tdata[5:0]} < 32'(MAX_KEYS));
        in_req.slot      = s_tdata[5:0];
        in_req.time_q16  = s_tdata[37:6];
        in_req.value_x   = s_tdata[69:38];
        in_req.value_y   = s_tdata[101:70];
        in_req.value_z   = s_tdata[133:102];
    end

    assign s_tready  = (count_reg != 2'd2);
    assign push      = s_tvalid && s_tready;
    assign req_valid = (count_reg != 2'd0);
    assign req       = fifo_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_reg[wr_ptr_reg] <= in_req;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (req_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !req_pop)
                count_reg <= count_reg + 2'd1;
            else if (req_pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

endmodule

// ----- rtl/core/kvs_div.sv -----
// ----------------------------------------------------------------------------
// kvs_div
// radix-2 restoring divider for the Q16.16 blend factor, saturated
// ----------------------------------------------------------------------------
module kvs_div
    import kvs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  kvs_div_req_t dreq,
    output kvs_div_rsp_t drsp
);

    logic [32:0]      rem_reg;
    logic [QUO_W-1:0] quo_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic [31:0]      dmag_reg;
    logic             neg_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [31:0]      f_reg;
    logic [32:0]      nmag;
    logic [32:0]      dmag;
    logic [32:0]      shifted;
    logic             qbit;
    logic [32:0]      rem_next;
    logic [QUO_W-1:0] quo_next;
    logic [31:0]      f_next;

    always_comb
    begin
        nmag     = dreq.num[32] ? 33'd0 - dreq.num : dreq.num;
        dmag     = dreq.den[32] ? 33'd0 - dreq.den : dreq.den;
        shifted  = {rem_reg[31:0], quo_reg[QUO_W-1]};
        qbit     = (shifted >= {1'b0, dmag_reg});
        rem_next = qbit ? shifted - {1'b0, dmag_reg} : shifted;
        quo_next = {quo_reg[QUO_W-2:0], qbit};
        if (!neg_reg)
        begin
            if (quo_next > {{(QUO_W-32){1'b0}}, 32'h7FFF_FFFF})
                f_next = 32'h7FFF_FFFF;
            else
                f_next = quo_next[31:0];
        end
        else
        begin
            if (quo_next > {{(QUO_W-32){1'b0}}, 32'h8000_0000})
                f_next = 32'h8000_0000;
            else
                f_next = 32'd0 - quo_next[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (dreq.start && !busy_reg)
                busy_reg <= 1'b1;
            else if (busy_reg && cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (dreq.start && !busy_reg)
        begin
            rem_reg  <= 33'd0;
            quo_reg  <= {nmag[31:0], 16'd0};
            dmag_reg <= dmag[31:0];
            neg_reg  <= dreq.num[32] ^ dreq.den[32];
            cnt_reg  <= QCNT_W'(QUO_W - 1);
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            cnt_reg <= cnt_reg - QCNT_W'(1);
            if (cnt_reg == '0)
                f_reg <= f_next;
        end
    end

    assign drsp.busy = busy_reg;
    assign drsp.done = done_reg;
    assign drsp.f    = f_reg;

endmodule

// ----- rtl/core/kvs_back.sv -----
// ----------------------------------------------------------------------------
// kvs_back
// key table, interval scan, blend sequencer and output register
// ----------------------------------------------------------------------------
module kvs_back
    import kvs_pkg::*;
#(
    parameter int MAX_KEYS = 64,
    parameter int AW       = 6,
    parameter int CW       = 7
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_pop,
    input  kvs_req_t              req,
    input  logic [CW-1:0]         eff_cnt,
    output kvs_div_req_t          dreq,
    input  kvs_div_rsp_t          drsp,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_FETCH = 3'd2;
    localparam logic [2:0] ST_LOAD  = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_MUL   = 3'd5;
    localparam logic [2:0] ST_ACC   = 3'd6;
    localparam logic [2:0] ST_DONE  = 3'd7;

    kvs_key_t          mem [MAX_KEYS];
    kvs_key_t          rdata_reg;
    logic [AW-1:0]     rd_addr;
    logic [2:0]        state_reg;
    logic [31:0]       t_reg;
    logic [AW-1:0]     scan_idx_reg;
    logic [AW-1:0]     cmp_idx_reg;
    logic              cmp_valid_reg;
    logic [AW-1:0]     hi_reg;
    logic [AW-1:0]     lo_addr;
    logic [AW-1:0]     last_idx;
    kvs_key_t          hi_ent_reg;
    kvs_key_t          lo_ent_reg;
    logic              start_reg;
    logic [32:0]       num_reg;
    logic [32:0]       den_reg;
    logic [32:0]       den_now;
    logic [31:0]       f_reg;
    logic [1:0]        comp_reg;
    logic signed [64:0] prod_reg;
    logic [31:0]       vlo;
    logic [31:0]       vhi;
    logic signed [32:0] diff;
    logic signed [49:0] sum;
    logic [31:0]       sat;
    logic [31:0]       res_x_reg;
    logic [31:0]       res_y_reg;
    logic [31:0]       res_z_reg;
    logic              out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic              out_load;

    assign last_idx = AW'(eff_cnt - CW'(1));
    assign lo_addr  = (hi_reg == '0) ? '0 : hi_reg - AW'(1);
    assign rd_addr  = (state_reg == ST_SCAN) ? scan_idx_reg : lo_addr;
    assign req_pop  = (state_reg == ST_IDLE) && req_valid;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);
    assign den_now  = (hi_reg == '0) ? 33'd0
                    : {1'b0, hi_ent_reg.time_q16} - {1'b0, rdata_reg.time_q16};

    always_ff @(posedge clk)
    begin
        if (req_pop && !req.is_sample && req.wr_ok)
        begin
            mem[AW'(req.slot)] <= '{req.time_q16, req.value_x, req.value_y, req.value_z};
        end
        rdata_reg <= mem[rd_addr];
    end

    always_comb
    begin
        case (comp_reg)
            2'd0:
            begin
                vlo = lo_ent_reg.value_x;
                vhi = hi_ent_reg.value_x;
            end
            2'd1:
            begin
                vlo = lo_ent_reg.value_y;
                vhi = hi_ent_reg.value_y;
            end
            default:
            begin
                vlo = lo_ent_reg.value_z;
                vhi = hi_ent_reg.value_z;
            end
        endcase
        diff = $signed({vhi[31], vhi}) - $signed({vlo[31], vlo});
        sum  = $signed({{18{vlo[31]}}, vlo}) + $signed({prod_reg[64], prod_reg[64:16]});
        if (sum > 50'sd2147483647)
            sat = 32'h7FFF_FFFF;
        else if (sum < -50'sd2147483648)
            sat = 32'h8000_0000;
        else
            sat = sum[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cmp_valid_reg <= 1'b0;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            start_reg <= 1'b0;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (req_valid && req.is_sample)
                    begin
                        cmp_valid_reg <= 1'b0;
                        if (eff_cnt < CW'(2))
                            state_reg <= ST_FETCH;
                        else
                            state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    cmp_valid_reg <= 1'b1;
                    if (cmp_valid_reg)
                    begin
                        if (t_reg < rdata_reg.time_q16 || cmp_idx_reg == last_idx)
                            state_reg <= ST_FETCH;
                    end
                end
                ST_FETCH: state_reg <= ST_LOAD;
                ST_LOAD:
                begin
                    if (den_now == 33'd0)
                        state_reg <= ST_MUL;
                    else
                    begin
                        start_reg <= 1'b1;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (drsp.done)
                        state_reg <= ST_MUL;
                end
                ST_MUL: state_reg <= ST_ACC;
                ST_ACC:
                begin
                    if (comp_reg == 2'd2)
                        state_reg <= ST_DONE;
                    else
                        state_reg <= ST_MUL;
                end
                ST_DONE:
                begin
                    if (out_load)
                        state_reg <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                t_reg        <= req.time_q16;
                hi_reg       <= '0;
                scan_idx_reg <= AW'(1);
                comp_reg     <= 2'd0;
            end
            ST_SCAN:
            begin
                cmp_idx_reg <= scan_idx_reg;
                if (scan_idx_reg != last_idx)
                    scan_idx_reg <= scan_idx_reg + AW'(1);
                if (cmp_valid_reg && t_reg < rdata_reg.time_q16)
                begin
                    hi_reg     <= cmp_idx_reg;
                    hi_ent_reg <= rdata_reg;
                end
            end
            ST_LOAD:
            begin
                lo_ent_reg <= rdata_reg;
                if (hi_reg == '0)
                    hi_ent_reg <= rdata_reg;
                num_reg <= {1'b0, t_reg} - {1'b0, rdata_reg.time_q16};
                den_reg <= den_now;
                f_reg   <= 32'd0;
            end
            ST_DIV:
            begin
                if (drsp.done)
                    f_reg <= drsp.f;
            end
            ST_MUL: prod_reg <= diff * $signed(f_reg);
            ST_ACC:
            begin
                case (comp_reg)
                    2'd0:    res_x_reg <= sat;
                    2'd1:    res_y_reg <= sat;
                    default: res_z_reg <= sat;
                endcase
                comp_reg <= comp_reg + 2'd1;
            end
            default: t_reg <= t_reg;
        endcase
        if (out_load)
            out_data_reg <= {res_z_reg, res_y_reg, res_x_reg};
    end

    assign dreq.start = start_reg;
    assign dreq.num   = num_reg;
    assign dreq.den   = den_reg;
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;

endmodule

// ----- rtl/core/keyframe_vec3_sampler.sv -----
// ----------------------------------------------------------------------------
// keyframe_vec3_sampler
// linear keyframe sampler for x, y, z in Q16.16 with a loadable key table
// ----------------------------------------------------------------------------
// Requests enter a two-entry queue and run one at a time. A key write to a
// valid slot is stored as it leaves the queue. A sample scans the table at
// one key per cycle through the single read port of the key memory (up to
// eff_count - 1 keys), fetches and loads the lower key, runs the
// one-bit-per-cycle divider for the blend factor (skipped on a zero-length
// interval), then blends the three components through one shared multiplier
// and hands the result to the output register.
// Results are never lost; new requests are queued while a result waits.
`include "keyframe_vec3_sampler_defines.svh"

module keyframe_vec3_sampler
    import kvs_pkg::*;
#(
    parameter int MAX_KEYS = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [6:0]            cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // key_index, time_q16, value_x, value_y, value_z, zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // op
    input  logic [0:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // out_x, out_y, out_z
    output logic [OUT_DATA_W-1:0] m_tdata
);

    localparam int AW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);

    logic          req_valid;
    logic          req_pop;
    kvs_req_t      req;
    logic [CW-1:0] eff_cnt;
    kvs_div_req_t  dreq;
    kvs_div_rsp_t  drsp;

    kvs_front #(
        .MAX_KEYS (MAX_KEYS),
        .CW       (CW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .req_valid (req_valid),
        .req_pop   (req_pop),
        .req       (req),
        .eff_cnt   (eff_cnt)
    );

    kvs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .dreq  (dreq),
        .drsp  (drsp)
    );

    kvs_back #(
        .MAX_KEYS (MAX_KEYS),
        .AW       (AW),
        .CW       (CW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_pop   (req_pop),
        .req       (req),
        .eff_cnt   (eff_cnt),
        .dreq      (dreq),
        .drsp      (drsp),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    `KVS_ASSERT_IMP(a_div_start_idle, dreq.start, !drsp.busy)
    `KVS_ASSERT_IMP(a_div_done_free, drsp.done, !drsp.busy && !dreq.start)
    `KVS_ASSERT_NXT(a_div_start_busy, dreq.start, drsp.busy)

endmodule
